@@ src/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// Used by spq_store and stable_priority_queue; depends on nothing.
package spq_pkg;

  // Store geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int ID_W    = 16;
  localparam int SVC_W   = 8;
  localparam int PRI_W   = 4;
  localparam int REQ_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int REG_W   = 4;

  // Command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // Configuration register indexes
  localparam logic REG_MIN_PRI = 1'b0;
  localparam logic REG_MAX_PRI = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SERVED   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Write request from the sequencer to the store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } store_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PLACE,
    ST_DEQ,
    ST_DONE
  } state_t;

endpackage

@@ src/stable_priority_queue.sv @@
// Top level of the stable priority queue: sequencer, clamp and count logic.
// Depends on spq_pkg and spq_store.
//
//  channel   signals                                        transfer when
//  -------   ---------------------------------------------  ---------------------
//  command   start, command, customer_id, service_code,     start & !busy
//            priority_request
//  result    done, status, served_id, served_service,       done (one cycle)
//            served_priority, entry_count
//  config    cfg_we, cfg_index, cfg_data                    cfg_we
//
// Entries sit in a circular buffer in service order. A dequeue reads the head
// and registers it in ST_DEQ before done in ST_DONE; from an empty store it goes
// straight to ST_DONE. An enqueue walks back from the tail through the single
// store read port, moving each lower-priority entry one slot down, with a read
// state and a compare state per entry moved; a drop into a full store goes
// straight to ST_DONE.
// rst is synchronous; it empties the queue and loads the register defaults.
// The result cannot be stalled; busy stays high until the cycle after done.
module stable_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic                          command,
  input  logic [spq_pkg::ID_W-1:0]      customer_id,
  input  logic [spq_pkg::SVC_W-1:0]     service_code,
  input  logic signed [spq_pkg::REQ_W-1:0] priority_request,
  output logic [spq_pkg::STAT_W-1:0]    status,
  output logic [spq_pkg::ID_W-1:0]      served_id,
  output logic [spq_pkg::SVC_W-1:0]     served_service,
  output logic [spq_pkg::PRI_W-1:0]     served_priority,
  output logic [spq_pkg::COUNT_W-1:0]   entry_count,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [spq_pkg::REG_W-1:0]     cfg_data
);
  import spq_pkg::*;

  state_t              state, state_next;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    pos;
  logic [CNT_W-1:0]    count;
  logic [STAT_W-1:0]   res_status;
  entry_t              item;
  logic [PRI_W-1:0]    min_pri, max_pri;

  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic                keep_place;
  logic [PRI_W-1:0]    clamped;
  logic signed [REQ_W-1:0] req_raised;
  store_wr_t           wr;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_data;

  // Map an offset from the head onto a slot of the circular buffer
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign accept   = start && (state == ST_IDLE);
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  // Stored entry of equal or higher priority keeps its slot ahead of the new one
  assign keep_place = (rd_data.pri >= item.pri);

  // Raise to the minimum first, then lower to the maximum
  always_comb begin
    req_raised = priority_request;
    if (priority_request < $signed({{(REQ_W-PRI_W){1'b0}}, min_pri})) begin
      req_raised = $signed({{(REQ_W-PRI_W){1'b0}}, min_pri});
    end
    clamped = req_raised[PRI_W-1:0];
    if (req_raised > $signed({{(REQ_W-PRI_W){1'b0}}, max_pri})) begin
      clamped = max_pri;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_DEQUEUE) begin
            state_next = is_empty ? ST_DONE : ST_DEQ;
          end else if (is_full) begin
            state_next = ST_DONE;
          end else begin
            state_next = is_empty ? ST_PLACE : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (keep_place) begin
          state_next = ST_DONE;
        end else if (pos == IDX_W'(1)) begin
          state_next = ST_PLACE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_PLACE: state_next = ST_DONE;
      ST_DEQ:   state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Store access and handshake outputs
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = slot_of(head, pos);
    wr.data = item;
    rd_addr = slot_of(head, pos - IDX_W'(1));
    busy    = 1'b1;
    done    = 1'b0;
    case (state)
      ST_IDLE: begin
        busy    = 1'b0;
        rd_addr = head;
      end
      ST_SCAN_CMP: begin
        wr.en   = 1'b1;
        wr.data = keep_place ? item : rd_data;
      end
      ST_PLACE: wr.en = 1'b1;
      ST_DONE:  done  = 1'b1;
      default: ;
    endcase
  end

  spq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      count      <= '0;
      res_status <= STATUS_ENQUEUED;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (command == CMD_DEQUEUE) begin
              res_status <= is_empty ? STATUS_EMPTY : STATUS_SERVED;
            end else begin
              res_status <= is_full ? STATUS_FULL : STATUS_ENQUEUED;
            end
          end
        end
        ST_SCAN_CMP: begin
          if (keep_place) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_PLACE: count <= count + CNT_W'(1);
        ST_DEQ: begin
          head  <= slot_of(head, IDX_W'(1));
          count <= count - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Working entry and scan position
  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= IDX_W'(count);
      if (command == CMD_DEQUEUE) begin
        item <= '0;
      end else begin
        item.id  <= customer_id;
        item.svc <= service_code;
        item.pri <= clamped;
      end
    end else if (state == ST_SCAN_CMP && !keep_place) begin
      pos <= pos - IDX_W'(1);
    end else if (state == ST_DEQ) begin
      item <= rd_data;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pri <= 4'd0;
      max_pri <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_PRI: min_pri <= cfg_data;
        REG_MAX_PRI: max_pri <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status          = res_status;
  assign served_id       = item.id;
  assign served_service  = item.svc;
  assign served_priority = item.pri;
  assign entry_count     = COUNT_W'(count);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_DEQUEUE && is_empty |=> done && status == STATUS_EMPTY)
    else $error("dequeue from empty store not reported at once");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_ENQUEUE && is_full |=> done && status == STATUS_FULL)
    else $error("enqueue into full store not dropped at once");

  a_served_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_SERVED |-> count + CNT_W'(1) == $past(count))
    else $error("serve did not lower the count by one");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

@@ src/spq_store.sv @@
// Entry store of the priority queue: one write port and one registered read port.
// Depends on spq_pkg.
module spq_store (
  input  logic                     clk,
  input  spq_pkg::store_wr_t       wr,
  input  logic [spq_pkg::IDX_W-1:0] rd_addr,
  output spq_pkg::entry_t          rd_data
);
  import spq_pkg::*;

  entry_t mem [CAPACITY];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
